// File: rtl/refcounted_page_allocator_defines.svh
// Assertion macros for the page allocator.
// The clock is clk_i and the active-low reset is rst_ni in every module that asserts.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define RPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, including during reset.
`define RPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RPA_ASSERT(lbl, prop, msg)
`define RPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/rpa_pkg.sv
`default_nettype none

package rpa_pkg;

  // Default geometry.
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;

  // Field widths.
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REF   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEREF = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFERENCED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP  = 2'd1;

  // Saturation limit of a reference count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register a new command from the ports
    logic decode;   // check the address and read the tables
    logic exec;     // update the tables and present the result
    logic clear;    // write one zero count of the reset sweep
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the sweep writes its last entry this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/refcounted_page_allocator.sv
// Page allocator with a LIFO free stack and one 7-bit reference count per page.
// After reset, busy stays high while the count table is swept to zero, one entry
// a cycle; configuration writes are taken throughout. A command transfer happens
// on a clock edge with start high and busy low. Each command passes through a
// decode cycle that checks the address and reads the count table or the stack,
// and an execute cycle that writes them back, so a new command can be taken in
// the execute cycle of the previous one. The result appears on the cycle after
// the execute cycle, marked by done_o for exactly one cycle; the receiver cannot
// stall, so it must take the result on that cycle. Configure the region only
// while no command is in flight.
`default_nettype none

module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Command channel.
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rpa_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [rpa_pkg::ADDR_W-1:0]     page_addr_i,
  // Result channel.
  output logic                                done_o,
  output logic [rpa_pkg::STATUS_W-1:0]        status_o,
  output logic [rpa_pkg::ADDR_W-1:0]          alloc_addr_o,
  output logic [rpa_pkg::COUNT_W-1:0]         ref_count_o,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rpa_pkg::ADDR_W-1:0]     cfg_data_i
);

  rpa_pkg::ctl_t ctl;
  rpa_pkg::sts_t sts;

  // Register writes are always accepted: ready is tied high.
  assign cfg_ready_o = 1'b1;

  rpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  rpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .page_addr_i  (page_addr_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o),
    .ref_count_o  (ref_count_o)
  );

endmodule

`default_nettype wire

// File: rtl/rpa_ctrl.sv
`default_nettype none

`include "refcounted_page_allocator_defines.svh"

module rpa_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  rpa_pkg::sts_t     sts_i,
  output rpa_pkg::ctl_t     ctl_o,
  output logic              busy_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Command strobes toward the datapath.
  always_comb begin
    ctl_o         = '0;
    ctl_o.capture = start && !busy_q;
    ctl_o.decode  = (state_q == S_DECODE);
    ctl_o.exec    = (state_q == S_EXEC);
    ctl_o.clear   = (state_q == S_CLEAR);
  end

  // Next state. A new command may be taken while the previous one executes.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE, S_EXEC: begin
        state_d = ctl_o.capture ? S_DECODE : S_IDLE;
      end
      S_DECODE: begin
        state_d = S_EXEC;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and the registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d == S_CLEAR) || (state_d == S_DECODE);
    end
  end

  assign busy_o = busy_q;

  `RPA_ASSERT(a_capture_to_decode, ctl_o.capture |=> state_q == S_DECODE,
              "accepted command did not enter decode")
  `RPA_ASSERT(a_decode_to_exec, state_q == S_DECODE |=> state_q == S_EXEC,
              "decode not followed by execute")
  `RPA_ASSERT(a_no_capture_in_clear, state_q == S_CLEAR |-> !ctl_o.capture,
              "command accepted during the count sweep")

endmodule

`default_nettype wire

// File: rtl/rpa_datapath.sv
`default_nettype none

`include "refcounted_page_allocator_defines.svh"

module rpa_datapath #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  rpa_pkg::ctl_t                         ctl_i,
  output rpa_pkg::sts_t                         sts_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rpa_pkg::ADDR_W-1:0]       cfg_data_i,
  input  wire logic [rpa_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [rpa_pkg::ADDR_W-1:0]       page_addr_i,
  output logic                                  done_o,
  output logic [rpa_pkg::STATUS_W-1:0]          status_o,
  output logic [rpa_pkg::ADDR_W-1:0]            alloc_addr_o,
  output logic [rpa_pkg::COUNT_W-1:0]           ref_count_o
);

  localparam int AW      = rpa_pkg::ADDR_W;
  localparam int CW      = rpa_pkg::COUNT_W;
  localparam int IDX_W   = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  // Page-number widths: address high part, rounded base, and the limit.
  localparam int HI_W    = AW - PAGE_SHIFT;
  localparam int FP_W    = AW + 1 - PAGE_SHIFT;
  localparam int LPG_W   = ((FP_W > DEPTH_W) ? FP_W : DEPTH_W) + 1;
  localparam logic [AW:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;

  // Configuration and values derived from it at the write.
  logic [AW-1:0]    base_q, top_q;
  logic [FP_W-1:0]  fp_pg_q;
  logic [LPG_W-1:0] lim_pg_q;
  logic [AW:0]      cfg_round;
  logic [FP_W-1:0]  cfg_fp_pg;

  assign cfg_round = {1'b0, cfg_data_i} + PAGE_MASK;
  assign cfg_fp_pg = cfg_round[AW:PAGE_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      top_q    <= '0;
      fp_pg_q  <= '0;
      lim_pg_q <= LPG_W'(NUM_PAGES);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpa_pkg::REG_REGION_BASE: begin
          base_q   <= cfg_data_i;
          fp_pg_q  <= cfg_fp_pg;
          lim_pg_q <= LPG_W'(cfg_fp_pg) + LPG_W'(NUM_PAGES);
        end
        rpa_pkg::REG_REGION_TOP: begin
          top_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Command register, loaded on each accepted transfer.
  logic [rpa_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]             addr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_i;
      addr_q <= page_addr_i;
    end
  end

  // Address check and page number.
  logic [HI_W-1:0]  addr_hi, idx_diff;
  logic [IDX_W-1:0] idx;
  logic             addr_ok;

  assign addr_hi  = addr_q[AW-1:PAGE_SHIFT];
  assign idx_diff = addr_hi - HI_W'(fp_pg_q);
  assign idx      = IDX_W'(idx_diff);
  assign addr_ok  = (addr_q[PAGE_SHIFT-1:0] == '0) && (addr_q >= base_q) &&
                    (addr_q < top_q) && (LPG_W'(addr_hi) < lim_pg_q);

  // Stack pointer and the sweep counter.
  logic [DEPTH_W-1:0] depth_q;
  logic [IDX_W-1:0]   clr_q;
  logic [DEPTH_W-1:0] depth_dec;
  logic               stk_empty;

  assign depth_dec = depth_q - DEPTH_W'(1);
  assign stk_empty = (depth_q == '0);
  assign sts_o.clear_last = (clr_q == IDX_W'(NUM_PAGES - 1));

  // Execute-stage registers, loaded at the end of decode.
  logic [rpa_pkg::CMD_W-1:0] op_q;
  logic                      ok_q;
  logic                      empty_q;
  logic [IDX_W-1:0]          idx_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.decode) begin
      op_q    <= cmd_q;
      ok_q    <= addr_ok;
      empty_q <= stk_empty;
      idx_q   <= idx;
    end
  end

  // Count table and free stack, each with one read and one write port.
  logic [CW-1:0]    ref_mem [NUM_PAGES];
  logic [IDX_W-1:0] stk_mem [NUM_PAGES];
  logic [CW-1:0]    ref_rd_q;
  logic [IDX_W-1:0] stk_rd_q;
  logic             ref_we, stk_push, stk_pop;
  logic [CW-1:0]    ref_wd;

  always_ff @(posedge clk_i) begin
    if (ctl_i.decode && addr_ok) begin
      ref_rd_q <= ref_mem[idx];
    end
    if (ctl_i.clear) begin
      ref_mem[clr_q] <= '0;
    end else if (ref_we) begin
      ref_mem[idx_q] <= ref_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.decode && (cmd_q == rpa_pkg::CMD_ALLOC) && !stk_empty) begin
      stk_rd_q <= stk_mem[depth_dec[IDX_W-1:0]];
    end
    if (stk_push) begin
      stk_mem[depth_q[IDX_W-1:0]] <= idx_q;
    end
  end

  // Execute: result fields and table updates.
  logic [rpa_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]                res_addr;
  logic [CW-1:0]                res_count;
  logic [HI_W-1:0]              alloc_hi;

  assign alloc_hi = HI_W'(fp_pg_q) + HI_W'(stk_rd_q);

  always_comb begin
    res_status = rpa_pkg::ST_OK;
    res_addr   = '0;
    res_count  = '0;
    ref_we     = 1'b0;
    ref_wd     = ref_rd_q;
    stk_push   = 1'b0;
    stk_pop    = 1'b0;
    if (ctl_i.exec) begin
      if (op_q == rpa_pkg::CMD_ALLOC) begin
        if (empty_q) begin
          res_status = rpa_pkg::ST_EMPTY;
        end else begin
          stk_pop  = 1'b1;
          res_addr = {alloc_hi, {PAGE_SHIFT{1'b0}}};
        end
      end else if (!ok_q) begin
        res_status = rpa_pkg::ST_BADADDR;
      end else begin
        case (op_q)
          rpa_pkg::CMD_FREE: begin
            if (ref_rd_q != '0) begin
              res_status = rpa_pkg::ST_REFERENCED;
            end else if (depth_q == DEPTH_W'(NUM_PAGES)) begin
              res_status = rpa_pkg::ST_FULL;
            end else begin
              stk_push = 1'b1;
            end
          end
          rpa_pkg::CMD_REF: begin
            res_count = ref_rd_q;
            if (ref_rd_q < rpa_pkg::COUNT_MAX) begin
              ref_we = 1'b1;
              ref_wd = ref_rd_q + CW'(1);
            end
          end
          rpa_pkg::CMD_DEREF: begin
            if (ref_rd_q != '0) begin
              ref_we = 1'b1;
              ref_wd = ref_rd_q - CW'(1);
            end
            res_count = ref_wd;
          end
          rpa_pkg::CMD_QUERY: begin
            res_count = ref_rd_q;
          end
          default: begin
            res_status = rpa_pkg::ST_BADADDR;
          end
        endcase
      end
    end
  end

  // Stack pointer, sweep counter and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      clr_q   <= '0;
      done_o  <= 1'b0;
    end else begin
      if (stk_push) begin
        depth_q <= depth_q + DEPTH_W'(1);
      end else if (stk_pop) begin
        depth_q <= depth_dec;
      end
      if (ctl_i.clear) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      done_o <= ctl_i.exec;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      status_o     <= res_status;
      alloc_addr_o <= res_addr;
      ref_count_o  <= res_count;
    end
  end

  `RPA_ASSERT(a_depth_bound, depth_q <= DEPTH_W'(NUM_PAGES),
              "free stack depth beyond the page count")
  `RPA_ASSERT(a_done_single, done_o |=> !done_o,
              "result strobe high on two cycles in a row")
  `RPA_ASSERT(a_fail_no_addr, done_o && (status_o != rpa_pkg::ST_OK) |-> alloc_addr_o == '0,
              "failed command returned a page address")

endmodule

`default_nettype wire
